@@ design/generational_handle_allocator_macros.svh @@
// Assertion helpers for the generational handle allocator.
// Each expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_MACROS_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_MACROS_SVH

// Same-cycle implication.
`define GHA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GHA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/gha_pkg.sv @@
// ----------------------------------------------------------------------------
// gha_pkg
// Shared types and codes for the generational handle allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package gha_pkg;

  localparam logic [1:0] MODE_CREATE    = 2'd0;
  localparam logic [1:0] MODE_DESTROY   = 2'd1;
  localparam logic [1:0] MODE_CHECK     = 2'd2;
  localparam logic [1:0] MODE_ENUMERATE = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_NONE    = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,    // waiting for start
    S_POP,     // free stack entry read back, version read issued
    S_CRD,     // version of popped slot available
    S_VCHK,    // version of handle slot available (destroy / check)
    S_ENUM,    // walking slots, one version read per cycle
    S_EFLUSH   // emit the held last live handle
  } state_t;

endpackage

`default_nettype wire

@@ design/generational_handle_allocator.sv @@
// ----------------------------------------------------------------------------
// generational_handle_allocator
// Allocates, frees, checks and lists handles of {slot index, version}.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Every result is shown
// for exactly one cycle with out_valid high and must be captured then; there
// is no back-pressure. The final result of a command appears in the cycle after
// its last busy cycle. Create from a fresh slot, create on a full table and
// enumerate with no slot ever used answer straight from idle and are never busy;
// check and destroy wait for a version read; create that reuses a freed slot
// reads the free stack, then the version table. Enumerate reads one version per
// used slot and emits one result per live slot as it walks. The steps come from
// the single registered read port of the version table and of the free stack.
`default_nettype none

`include "generational_handle_allocator_macros.svh"

module generational_handle_allocator #(
  parameter int INDEX_BITS   = 6,
  parameter int VERSION_BITS = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [1:0]                         in_mode,
  input  wire logic [INDEX_BITS+VERSION_BITS-1:0] in_entity_handle,
  output logic                                    out_valid,
  output logic [INDEX_BITS+VERSION_BITS-1:0]      out_result_handle,
  output logic [1:0]                              out_status,
  output logic                                    out_last
);

  localparam int HW    = INDEX_BITS + VERSION_BITS;
  localparam int SLOTS = 1 << INDEX_BITS;
  localparam int CW    = INDEX_BITS + 1;

  localparam logic [CW-1:0]           SLOTS_C = CW'(SLOTS);
  localparam logic [CW-1:0]           ONE_C   = CW'(1);
  localparam logic [VERSION_BITS-1:0] VER_ONE = VERSION_BITS'(1);

  // Control state
  gha_pkg::state_t state_r, state_nxt;
  logic [1:0]            mode_r, mode_nxt;
  logic [HW-1:0]         hdl_r, hdl_nxt;
  logic [INDEX_BITS-1:0] idx_r, idx_nxt;
  logic [CW-1:0]         fc_r, fc_nxt;        // free stack depth
  logic [CW-1:0]         su_r, su_nxt;        // slots ever handed out
  logic [SLOTS-1:0]      alive_r;
  logic                  alive_set, alive_clr;
  logic [INDEX_BITS-1:0] alive_idx;
  logic [INDEX_BITS-1:0] ed_r, ed_nxt;        // slot whose version is in vt_rdata_r
  logic                  pend_v_r, pend_v_nxt;
  logic [HW-1:0]         pend_h_r, pend_h_nxt;

  // Result registers
  logic          out_valid_r, out_valid_nxt;
  logic [HW-1:0] out_handle_r, out_handle_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic          out_last_r, out_last_nxt;

  // Version table
  logic [VERSION_BITS-1:0] vt_mem [SLOTS];
  logic                    vt_we;
  logic [INDEX_BITS-1:0]   vt_waddr, vt_raddr;
  logic [VERSION_BITS-1:0] vt_wdata, vt_rdata_r;

  // Free stack
  logic [INDEX_BITS-1:0] fs_mem [SLOTS];
  logic                  fs_we;
  logic [INDEX_BITS-1:0] fs_waddr, fs_raddr, fs_wdata, fs_rdata_r;

  logic [INDEX_BITS-1:0]   in_idx, h_idx;
  logic [VERSION_BITS-1:0] h_ver, ver_bump;
  logic                    h_live;

  assign in_idx = in_entity_handle[HW-1:VERSION_BITS];
  assign h_idx  = hdl_r[HW-1:VERSION_BITS];
  assign h_ver  = hdl_r[VERSION_BITS-1:0];

  // Handle zero never matches: no slot ever holds version zero.
  assign h_live = (hdl_r != '0) && ({1'b0, h_idx} < su_r) && alive_r[h_idx] &&
                  (vt_rdata_r == h_ver);

  assign ver_bump = ((vt_rdata_r + VER_ONE) == '0) ? VER_ONE : (vt_rdata_r + VER_ONE);

  always_ff @(posedge clk) begin
    if (vt_we) begin
      vt_mem[vt_waddr] <= vt_wdata;
    end
    vt_rdata_r <= vt_mem[vt_raddr];
  end

  always_ff @(posedge clk) begin
    if (fs_we) begin
      fs_mem[fs_waddr] <= fs_wdata;
    end
    fs_rdata_r <= fs_mem[fs_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gha_pkg::S_IDLE;
      fc_r        <= '0;
      su_r        <= '0;
      alive_r     <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fc_r        <= fc_nxt;
      su_r        <= su_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (alive_set) begin
        alive_r[alive_idx] <= 1'b1;
      end else if (alive_clr) begin
        alive_r[alive_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    hdl_r        <= hdl_nxt;
    idx_r        <= idx_nxt;
    ed_r         <= ed_nxt;
    pend_h_r     <= pend_h_nxt;
    out_handle_r <= out_handle_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    hdl_nxt        = hdl_r;
    idx_nxt        = idx_r;
    fc_nxt         = fc_r;
    su_nxt         = su_r;
    ed_nxt         = ed_r;
    pend_v_nxt     = pend_v_r;
    pend_h_nxt     = pend_h_r;
    alive_set      = 1'b0;
    alive_clr      = 1'b0;
    alive_idx      = idx_r;
    out_valid_nxt  = 1'b0;
    out_handle_nxt = '0;
    out_status_nxt = gha_pkg::ST_OK;
    out_last_nxt   = 1'b1;
    vt_we          = 1'b0;
    vt_waddr       = su_r[INDEX_BITS-1:0];
    vt_wdata       = VER_ONE;
    vt_raddr       = in_idx;
    fs_we          = 1'b0;
    fs_waddr       = fc_r[INDEX_BITS-1:0];
    fs_wdata       = h_idx;
    fs_raddr       = fc_r[INDEX_BITS-1:0] - INDEX_BITS'(1);

    case (state_r)
      gha_pkg::S_IDLE: begin
        if (start) begin
          mode_nxt = in_mode;
          hdl_nxt  = in_entity_handle;
          case (in_mode)
            gha_pkg::MODE_CREATE: begin
              if (fc_r != '0) begin
                fc_nxt    = fc_r - ONE_C;
                state_nxt = gha_pkg::S_POP;
              end else if (su_r != SLOTS_C) begin
                // fresh slot starts at version one
                vt_we          = 1'b1;
                alive_set      = 1'b1;
                alive_idx      = su_r[INDEX_BITS-1:0];
                su_nxt         = su_r + ONE_C;
                out_valid_nxt  = 1'b1;
                out_handle_nxt = {su_r[INDEX_BITS-1:0], VER_ONE};
              end else begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = gha_pkg::ST_FULL;
              end
            end
            gha_pkg::MODE_DESTROY, gha_pkg::MODE_CHECK: begin
              state_nxt = gha_pkg::S_VCHK;
            end
            gha_pkg::MODE_ENUMERATE: begin
              if (su_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = gha_pkg::ST_NONE;
              end else begin
                vt_raddr   = '0;
                ed_nxt     = '0;
                pend_v_nxt = 1'b0;
                state_nxt  = gha_pkg::S_ENUM;
              end
            end
            default: ;
          endcase
        end
      end

      gha_pkg::S_POP: begin
        vt_raddr  = fs_rdata_r;
        idx_nxt   = fs_rdata_r;
        alive_set = 1'b1;
        alive_idx = fs_rdata_r;
        state_nxt = gha_pkg::S_CRD;
      end

      gha_pkg::S_CRD: begin
        out_valid_nxt  = 1'b1;
        out_handle_nxt = {idx_r, vt_rdata_r};
        state_nxt      = gha_pkg::S_IDLE;
      end

      gha_pkg::S_VCHK: begin
        out_valid_nxt = 1'b1;
        if (mode_r == gha_pkg::MODE_DESTROY) begin
          if (h_live && (fc_r != SLOTS_C)) begin
            vt_we     = 1'b1;
            vt_waddr  = h_idx;
            vt_wdata  = ver_bump;
            alive_clr = 1'b1;
            alive_idx = h_idx;
            fs_we     = 1'b1;
            fc_nxt    = fc_r + ONE_C;
          end else begin
            out_status_nxt = gha_pkg::ST_INVALID;
          end
        end else begin
          out_status_nxt = h_live ? gha_pkg::ST_OK : gha_pkg::ST_INVALID;
        end
        state_nxt = gha_pkg::S_IDLE;
      end

      gha_pkg::S_ENUM: begin
        // a live handle is held back one find so the final one can carry last
        vt_raddr = ed_r + INDEX_BITS'(1);
        ed_nxt   = ed_r + INDEX_BITS'(1);
        if (alive_r[ed_r]) begin
          if (pend_v_r) begin
            out_valid_nxt  = 1'b1;
            out_handle_nxt = pend_h_r;
            out_last_nxt   = 1'b0;
          end
          pend_v_nxt = 1'b1;
          pend_h_nxt = {ed_r, vt_rdata_r};
        end
        if (({1'b0, ed_r} + ONE_C) == su_r) begin
          state_nxt = gha_pkg::S_EFLUSH;
        end
      end

      gha_pkg::S_EFLUSH: begin
        out_valid_nxt = 1'b1;
        if (pend_v_r) begin
          out_handle_nxt = pend_h_r;
        end else begin
          out_status_nxt = gha_pkg::ST_NONE;
        end
        state_nxt = gha_pkg::S_IDLE;
      end

      default: begin
        state_nxt = gha_pkg::S_IDLE;
      end
    endcase
  end

  assign busy              = (state_r != gha_pkg::S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_result_handle = out_handle_r;
  assign out_status        = out_status_r;
  assign out_last          = out_last_r;

  `GHA_ASSERT_SAME(a_err_no_handle, out_valid_r && (out_status_r != gha_pkg::ST_OK), (out_handle_r == '0) && out_last_r, "error result carries a handle or is not last")
  `GHA_ASSERT_SAME(a_free_le_used, 1'b1, fc_r <= su_r, "free stack deeper than slots handed out")
  `GHA_ASSERT_NEXT(a_accept_progress, start && !busy, busy || out_valid_r, "accepted command made no progress")
  `GHA_ASSERT_SAME(a_enum_in_range, state_r == gha_pkg::S_ENUM, {1'b0, ed_r} < su_r, "enumerate walked past used slots")

endmodule

`default_nettype wire

@@ sim/generational_handle_allocator_tb.sv @@
// ----------------------------------------------------------------------------
// generational_handle_allocator_tb
// Self-checking bench for the generational handle allocator. A typed list of
// commands covers reset, the invalid and none codes, slot reuse and the empty listing.
// The bench then fills the table, hits the full case and lists every slot,
// and ends with random command traffic. A local model of the slot table
// predicts every result. Results are compared in order as each one is shown.
// ----------------------------------------------------------------------------
`default_nettype none

module generational_handle_allocator_tb;

  localparam int INDEX_W     = 6;
  localparam int VER_W       = 8;
  localparam int HANDLE_W    = INDEX_W + VER_W;
  localparam int SLOTS       = 1 << INDEX_W;
  localparam int IDLE_LIMIT  = 2000;
  localparam int TAIL_CYCLES = SLOTS + 8;
  localparam int RANDOM_CMDS = 330;
  localparam int MAX_REPORTS = 10;

  typedef logic [HANDLE_W-1:0] handle_t;

  typedef struct packed {
    handle_t    handle;
    logic [1:0] status;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0] mode;
    handle_t    handle;
    logic       typed;
    handle_t    exp_handle;
    logic [1:0] exp_status;
    logic       exp_last;
  } row_t;

  // Expected result typed in where it is obvious; other rows use the model.
  localparam int DIR_COUNT = 23;
  localparam row_t DIR_ROWS [DIR_COUNT] = '{
    '{gha_pkg::MODE_ENUMERATE, 14'h0000, 1'b1, 14'h0000, gha_pkg::ST_NONE,    1'b1},
    '{gha_pkg::MODE_CHECK,     14'h0000, 1'b1, 14'h0000, gha_pkg::ST_INVALID, 1'b1},
    '{gha_pkg::MODE_DESTROY,   14'h0000, 1'b1, 14'h0000, gha_pkg::ST_INVALID, 1'b1},
    '{gha_pkg::MODE_CREATE,    14'h3fff, 1'b1, 14'h0001, gha_pkg::ST_OK,      1'b1},
    '{gha_pkg::MODE_CREATE,    14'h0000, 1'b1, 14'h0101, gha_pkg::ST_OK,      1'b1},
    '{gha_pkg::MODE_CHECK,     14'h0001, 1'b1, 14'h0000, gha_pkg::ST_OK,      1'b1},
    '{gha_pkg::MODE_CHECK,     14'h0002, 1'b1, 14'h0000, gha_pkg::ST_INVALID, 1'b1},
    '{gha_pkg::MODE_CHECK,     14'h3fff, 1'b1, 14'h0000, gha_pkg::ST_INVALID, 1'b1},
    '{gha_pkg::MODE_ENUMERATE, 14'h0000, 1'b0, 14'h0000, gha_pkg::ST_OK,      1'b0},
    '{gha_pkg::MODE_DESTROY,   14'h0001, 1'b1, 14'h0000, gha_pkg::ST_OK,      1'b1},
    '{gha_pkg::MODE_CHECK,     14'h0001, 1'b1, 14'h0000, gha_pkg::ST_INVALID, 1'b1},
    '{gha_pkg::MODE_DESTROY,   14'h0001, 1'b1, 14'h0000, gha_pkg::ST_INVALID, 1'b1},
    '{gha_pkg::MODE_ENUMERATE, 14'h2aaa, 1'b0, 14'h0000, gha_pkg::ST_OK,      1'b0},
    '{gha_pkg::MODE_CREATE,    14'h1555, 1'b1, 14'h0002, gha_pkg::ST_OK,      1'b1},
    '{gha_pkg::MODE_DESTROY,   14'h0101, 1'b1, 14'h0000, gha_pkg::ST_OK,      1'b1},
    '{gha_pkg::MODE_DESTROY,   14'h0002, 1'b1, 14'h0000, gha_pkg::ST_OK,      1'b1},
    '{gha_pkg::MODE_ENUMERATE, 14'h0000, 1'b1, 14'h0000, gha_pkg::ST_NONE,    1'b1},
    '{gha_pkg::MODE_CREATE,    14'h0000, 1'b1, 14'h0003, gha_pkg::ST_OK,      1'b1},
    '{gha_pkg::MODE_CREATE,    14'h0000, 1'b1, 14'h0102, gha_pkg::ST_OK,      1'b1},
    '{gha_pkg::MODE_CHECK,     14'h0102, 1'b1, 14'h0000, gha_pkg::ST_OK,      1'b1},
    '{gha_pkg::MODE_DESTROY,   14'h0103, 1'b1, 14'h0000, gha_pkg::ST_INVALID, 1'b1},
    '{gha_pkg::MODE_CHECK,     14'h0200, 1'b1, 14'h0000, gha_pkg::ST_INVALID, 1'b1},
    '{gha_pkg::MODE_ENUMERATE, 14'h3fff, 1'b0, 14'h0000, gha_pkg::ST_OK,      1'b0}
  };

  logic       clk              = 1'b0;
  logic       rst_n            = 1'b0;
  logic       start            = 1'b0;
  logic [1:0] in_mode          = gha_pkg::MODE_CREATE;
  handle_t    in_entity_handle = '0;
  logic       busy;
  logic       out_valid;
  handle_t    out_result_handle;
  logic [1:0] out_status;
  logic       out_last;

  generational_handle_allocator #(
    .INDEX_BITS  (INDEX_W),
    .VERSION_BITS(VER_W)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_entity_handle (in_entity_handle),
    .out_valid        (out_valid),
    .out_result_handle(out_result_handle),
    .out_status       (out_status),
    .out_last         (out_last)
  );

  initial forever #5 clk = ~clk;

  // Slot table model
  logic [VER_W-1:0]   slot_ver  [SLOTS];
  bit                 slot_live [SLOTS];
  logic [INDEX_W-1:0] free_lifo [SLOTS];
  int                 free_depth = 0;
  int                 fresh_next = 0;
  int                 live_total = 0;
  result_t            pending_q [$];

  int cmd_count    = 0;
  int result_count = 0;
  int err_count    = 0;
  int idle_cycles  = 0;
  int burst_left   = 0;
  int mode_hits [4] = '{0, 0, 0, 0};

  // Append one predicted result to the tail of the expected list.
  function automatic void expect_result(handle_t h, logic [1:0] st, logic lst);
    result_t r;
    r = '{h, st, lst};
    pending_q.insert(pending_q.size(), r);
  endfunction

  function automatic bit handle_live(handle_t h);
    logic [INDEX_W-1:0] idx;
    idx = h[HANDLE_W-1:VER_W];
    if (h == '0) return 1'b0;
    return (int'(idx) < fresh_next) && slot_live[idx] && (slot_ver[idx] == h[VER_W-1:0]);
  endfunction

  task automatic predict_cmd(input logic [1:0] mode, input handle_t h);
    logic [INDEX_W-1:0] idx;
    logic [VER_W-1:0]   bumped;
    int                 n;
    idx = h[HANDLE_W-1:VER_W];
    n = 0;
    case (mode)
      gha_pkg::MODE_CREATE: begin
        if (free_depth > 0) begin
          free_depth--;
          idx = free_lifo[free_depth];
          slot_live[idx] = 1'b1;
          live_total++;
          expect_result(handle_t'({idx, slot_ver[idx]}), gha_pkg::ST_OK, 1'b1);
        end else if (fresh_next < SLOTS) begin
          idx = INDEX_W'(fresh_next);
          slot_ver[idx] = VER_W'(1);
          slot_live[idx] = 1'b1;
          fresh_next++;
          live_total++;
          expect_result(handle_t'({idx, slot_ver[idx]}), gha_pkg::ST_OK, 1'b1);
        end else begin
          expect_result(handle_t'(0), gha_pkg::ST_FULL, 1'b1);
        end
      end
      gha_pkg::MODE_DESTROY: begin
        if (handle_live(h) && free_depth < SLOTS) begin
          bumped = slot_ver[idx] + VER_W'(1);
          if (bumped == '0) bumped = VER_W'(1);
          slot_ver[idx] = bumped;
          slot_live[idx] = 1'b0;
          free_lifo[free_depth] = idx;
          free_depth++;
          live_total--;
          expect_result(handle_t'(0), gha_pkg::ST_OK, 1'b1);
        end else begin
          expect_result(handle_t'(0), gha_pkg::ST_INVALID, 1'b1);
        end
      end
      gha_pkg::MODE_CHECK: begin
        expect_result(handle_t'(0),
                      handle_live(h) ? gha_pkg::ST_OK : gha_pkg::ST_INVALID, 1'b1);
      end
      default: begin
        for (int i = 0; i < fresh_next; i++) begin
          if (slot_live[i]) begin
            expect_result(handle_t'({INDEX_W'(i), slot_ver[i]}), gha_pkg::ST_OK, 1'b0);
            n++;
          end
        end
        if (n == 0) expect_result(handle_t'(0), gha_pkg::ST_NONE, 1'b1);
        else pending_q[pending_q.size()-1].last = 1'b1;
      end
    endcase
  endtask

  // Result check: one transfer per cycle with out_valid, no back-pressure.
  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid) begin
        got = '{out_result_handle, out_status, out_last};
        result_count++;
        if (pending_q.size() == 0) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("%0t: unexpected result handle=%h status=%0d last=%0b",
                     $realtime, got.handle, got.status, got.last);
        end else begin
          want = pending_q.pop_front();
          if (got.handle !== want.handle || got.status !== want.status ||
              got.last !== want.last) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
              $display("%0t: mismatch: exp %h/%0d/%0b, got %h/%0d/%0b (handle/status/last)",
                       $realtime, want.handle, want.status, want.last,
                       got.handle, got.status, got.last);
          end
        end
      end
    end
  end

  // Drive one command, wait until it is no longer busy, then pace the sender in bursts.
  task automatic issue(input logic [1:0] mode, input handle_t h,
                       input bit typed = 1'b0, input result_t typed_res = '0);
    int gap;
    start            <= 1'b1;
    in_mode          <= mode;
    in_entity_handle <= h;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_cmd(mode, h);
    if (typed) pending_q[pending_q.size()-1] = typed_res;
    cmd_count++;
    mode_hits[mode]++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(0, 10);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Hold the sender off until every predicted result has come back.
  task automatic settle();
    if (pending_q.size() != 0) begin
      start <= 1'b0;
      while (pending_q.size() != 0) @(posedge clk);
    end
  endtask

  function automatic handle_t any_live();
    int base;
    int idx;
    base = $urandom_range(0, SLOTS - 1);
    for (int k = 0; k < SLOTS; k++) begin
      idx = (base + k) % SLOTS;
      if (idx < fresh_next && slot_live[idx])
        return handle_t'({INDEX_W'(idx), slot_ver[idx]});
    end
    return '0;
  endfunction

  // Arbitrary, stale-version or current-version handle of a random slot
  function automatic handle_t bogus_handle();
    int idx;
    idx = $urandom_range(0, SLOTS - 1);
    case ($urandom_range(0, 2))
      0: return handle_t'($urandom);
      1: return handle_t'({INDEX_W'(idx), slot_ver[idx] - VER_W'(1)});
      default: return handle_t'({INDEX_W'(idx), slot_ver[idx]});
    endcase
  endfunction

  initial begin : stimulus
    result_t    want;
    handle_t    h;
    logic [1:0] m;
    int         roll;
    int         create_pct;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIR_COUNT; r++) begin
      want = '{DIR_ROWS[r].exp_handle, DIR_ROWS[r].exp_status, DIR_ROWS[r].exp_last};
      issue(DIR_ROWS[r].mode, DIR_ROWS[r].handle, DIR_ROWS[r].typed, want);
    end
    settle();

    // Fill every slot, hit the full case and list all 64 live handles.
    while (fresh_next < SLOTS || free_depth > 0)
      issue(gha_pkg::MODE_CREATE, handle_t'($urandom));
    issue(gha_pkg::MODE_CREATE, '0);
    issue(gha_pkg::MODE_ENUMERATE, '0);
    settle();

    for (int k = 0; k < RANDOM_CMDS; k++) begin
      roll = $urandom_range(0, 99);
      create_pct = (live_total > 40) ? 15 : ((live_total < 8) ? 55 : 35);
      h = handle_t'($urandom);
      if (roll < 6) begin
        m = gha_pkg::MODE_ENUMERATE;
      end else if (roll < 6 + create_pct) begin
        m = gha_pkg::MODE_CREATE;
      end else begin
        roll = $urandom_range(0, 99);
        m = ($urandom_range(0, 2) == 0) ? gha_pkg::MODE_CHECK : gha_pkg::MODE_DESTROY;
        if (roll < 75 && live_total > 0) h = any_live();
        else if (roll < 95) h = bogus_handle();
      end
      if (k % 140 == 139) settle();
      issue(m, h);
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_q.size() != 0) begin
      $display("%0d expected results never arrived", pending_q.size());
      err_count += pending_q.size();
    end
    $display("%0d commands (create %0d, destroy %0d, check %0d, enumerate %0d), %0d results",
             cmd_count, mode_hits[gha_pkg::MODE_CREATE], mode_hits[gha_pkg::MODE_DESTROY],
             mode_hits[gha_pkg::MODE_CHECK], mode_hits[gha_pkg::MODE_ENUMERATE],
             result_count);
    $display("full table and listing of %0d slots, slot reuse under random traffic, %0d errors",
             SLOTS, err_count);
    if (err_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin : watchdog
    wait (rst_n);
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+design
design/gha_pkg.sv
design/generational_handle_allocator.sv
sim/generational_handle_allocator_tb.sv
